>>> src/natpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// natpt_pkg
// Shared types and constants for the NAT port translation table.
// ----------------------------------------------------------------------------
package natpt_pkg;

  // default table depth
  localparam int TABLE_ENTRIES_DEF = 64;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_HIGH   = 2'd2;
  localparam int CFG_DATA_W = 32;

  // configuration reset values
  localparam logic [31:0] PUBLIC_ADDR_RST = 32'h0606_0606;
  localparam logic [15:0] PORT_LOW_RST    = 16'd1024;
  localparam logic [15:0] PORT_HIGH_RST   = 16'hFFFF;

  // result status codes
  localparam logic [1:0] STAT_HIT  = 2'd0;
  localparam logic [1:0] STAT_NEW  = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;
  localparam logic [1:0] STAT_FULL = 2'd3;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [31:0] priv_addr;
    logic [15:0] priv_port;
    logic [31:0] map_addr;
    logic [15:0] map_port;
  } entry_t;

endpackage : natpt_pkg
`default_nettype wire

>>> src/natpt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// natpt_ram
// Mapping table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module natpt_ram #(
  parameter int DEPTH = natpt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire                         clk,
  input  wire                         wr_en,
  input  wire [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire natpt_pkg::entry_t      wr_data,
  input  wire                         rd_en,
  input  wire [$clog2(DEPTH)-1:0]     rd_addr,
  output natpt_pkg::entry_t           rd_data
);
  import natpt_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : natpt_ram
`default_nettype wire

>>> src/nat_port_translation_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nat_port_translation_table
// Translates packet headers: outbound source pairs get a public mapping,
// inbound destination pairs are mapped back to the private pair.
// ----------------------------------------------------------------------------
// Scan: after start is taken the entries are read in order from entry 0; a
//   hit stops at the matching entry, a miss runs through every filled entry.
//   The scan reads one table entry a cycle through the memory's registered
//   read port and one shared comparator.
// A new item is taken only once the last one is done: busy drops in the
//   cycle that done is shown.
// Reset: clears the fill count (all entries free), the port counter and the
//   configuration registers; the table contents need no clearing pass.
// done is a one-cycle strobe; the receiver cannot stall it.
module nat_port_translation_table #(
  parameter int TABLE_ENTRIES = natpt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // item command
  input  wire                                  start,
  output logic                                 busy,
  input  wire                                  outbound,
  input  wire  [31:0]                          in_src_addr,
  input  wire  [15:0]                          in_src_port,
  input  wire  [31:0]                          in_dst_addr,
  input  wire  [15:0]                          in_dst_port,
  // result
  output logic                                 done,
  output logic [31:0]                          out_src_addr,
  output logic [15:0]                          out_src_port,
  output logic [31:0]                          out_dst_addr,
  output logic [15:0]                          out_dst_port,
  output logic [1:0]                           status,
  // configuration
  input  wire                                  cfg_wr,
  input  wire  [natpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [natpt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import natpt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state, state_next;

  // configuration
  logic [31:0] public_address;
  logic [15:0] port_low;
  logic [15:0] port_high;

  // table bookkeeping
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [15:0]      next_port, next_port_next;

  // scan sequencer
  logic [CNT_W-1:0] idx, idx_next;
  logic             pend, pend_next;

  // latched item
  logic        dir;
  logic [31:0] sa, da;
  logic [15:0] sp, dp;

  // result registers
  logic        done_next;
  logic [31:0] out_src_addr_next, out_dst_addr_next;
  logic [15:0] out_src_port_next, out_dst_port_next;
  logic [1:0]  status_next;

  // memory ports
  entry_t     rd_data;
  entry_t     wr_data;
  logic       wr_en;
  logic       rd_en;

  // shared comparator
  logic [31:0] key_addr, cmp_addr;
  logic [15:0] key_port, cmp_port;
  logic        match, resolve, scanning;

  natpt_ram #(
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign busy     = (state != ST_IDLE);
  assign scanning = (state == ST_SCAN);

  always_comb begin
    key_addr = dir ? sa : da;
    key_port = dir ? sp : dp;
    cmp_addr = dir ? rd_data.priv_addr : rd_data.map_addr;
    cmp_port = dir ? rd_data.priv_port : rd_data.map_port;
    match    = scanning && pend && (cmp_addr == key_addr) && (cmp_port == key_port);
    rd_en    = scanning && !match && (idx < fill_count);
    resolve  = scanning && !match && !rd_en && !pend;
    wr_en    = resolve && dir && (fill_count < FULL_COUNT);

    wr_data.priv_addr = sa;
    wr_data.priv_port = sp;
    wr_data.map_addr  = public_address;
    wr_data.map_port  = next_port;
  end

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    pend_next         = pend;
    fill_count_next   = fill_count;
    next_port_next    = next_port;
    done_next         = 1'b0;
    out_src_addr_next = out_src_addr;
    out_src_port_next = out_src_port;
    out_dst_addr_next = out_dst_addr;
    out_dst_port_next = out_dst_port;
    status_next       = status;

    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
          idx_next   = '0;
          pend_next  = 1'b0;
        end
      end
      ST_SCAN: begin
        pend_next = rd_en;
        if (rd_en) begin
          idx_next = idx + 1'b1;
        end
        if (match) begin
          state_next        = ST_IDLE;
          done_next         = 1'b1;
          status_next       = STAT_HIT;
          out_src_addr_next = dir ? rd_data.map_addr : sa;
          out_src_port_next = dir ? rd_data.map_port : sp;
          out_dst_addr_next = dir ? da : rd_data.priv_addr;
          out_dst_port_next = dir ? dp : rd_data.priv_port;
        end else if (resolve) begin
          state_next        = ST_IDLE;
          done_next         = 1'b1;
          out_src_addr_next = sa;
          out_src_port_next = sp;
          out_dst_addr_next = da;
          out_dst_port_next = dp;
          if (!dir) begin
            status_next = STAT_MISS;
          end else if (wr_en) begin
            // allocate the next public port and apply the new mapping
            status_next       = STAT_NEW;
            out_src_addr_next = public_address;
            out_src_port_next = next_port;
            fill_count_next   = fill_count + 1'b1;
            next_port_next    = (next_port >= port_high) ? port_low : next_port + 1'b1;
          end else begin
            status_next = STAT_FULL;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend       <= 1'b0;
      idx        <= '0;
      fill_count <= '0;
      next_port  <= PORT_LOW_RST;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      pend       <= pend_next;
      idx        <= idx_next;
      fill_count <= fill_count_next;
      next_port  <= next_port_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      public_address <= PUBLIC_ADDR_RST;
      port_low       <= PORT_LOW_RST;
      port_high      <= PORT_HIGH_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_PUBLIC_ADDR: public_address <= cfg_data[31:0];
        CFG_PORT_LOW:    port_low       <= cfg_data[15:0];
        CFG_PORT_HIGH:   port_high      <= cfg_data[15:0];
        default:         ;
      endcase
    end
  end

  // hold the item while it is scanned
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dir <= outbound;
      sa  <= in_src_addr;
      sp  <= in_src_port;
      da  <= in_dst_addr;
      dp  <= in_dst_port;
    end
  end

  always_ff @(posedge clk) begin
    out_src_addr <= out_src_addr_next;
    out_src_port <= out_src_port_next;
    out_dst_addr <= out_dst_addr_next;
    out_dst_port <= out_dst_port_next;
    status       <= status_next;
  end

  // a result only ever follows a scan cycle
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_SCAN))
    else $error("done without a preceding scan");

  assert property (@(posedge clk) disable iff (rst)
    fill_count <= FULL_COUNT)
    else $error("fill count beyond table depth");

  // the table grows only with a reported new mapping
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && fill_count != $past(fill_count)) |-> (done && status == STAT_NEW))
    else $error("fill count changed without a new mapping");

  assert property (@(posedge clk) disable iff (rst)
    (busy && !pend) |-> !match)
    else $error("comparison without read data");

endmodule : nat_port_translation_table
`default_nettype wire
